>>> sv/kwtok_pkg.sv
// ---------------------------------------------------------------------------
// kwtok_pkg
// shared types, constants and character-class helpers for the keyword tokenizer
// ---------------------------------------------------------------------------
package kwtok_pkg;

  // width of the wrapping byte counter and of the saturating length counter
  localparam int POS_BITS = 32;
  localparam int LEN_BITS = 16;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  // number of keyword bytes kept for matching
  localparam int PREFIX_BYTES = 6;

  // result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    KIND_TYPE    = 4'd0,
    KIND_SELF    = 4'd1,
    KIND_COLOR   = 4'd2,
    KIND_POS     = 4'd3,
    KIND_ENTITY  = 4'd4,
    KIND_NAME    = 4'd5,
    KIND_OPEN    = 4'd6,
    KIND_CLOSE   = 4'd7,
    KIND_COMMA   = 4'd8,
    KIND_COLON   = 4'd9,
    KIND_EQUAL   = 4'd10,
    KIND_NUMBER  = 4'd11,
    KIND_INVALID = 4'd12,
    KIND_EOF     = 4'd13
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_WORD   = 3'b010,
    MODE_NUMBER = 3'b100
  } mode_t;

  typedef logic [PREFIX_BYTES-1:0][7:0] prefix_t;

  // one queued token
  typedef struct packed {
    kind_t       kind;
    logic [31:0] start_pos;
    logic [15:0] length;
    logic        last;
  } token_t;

  // keywords, first byte in the low byte, zero padded
  localparam prefix_t KW_TYPE   = {8'h00, 8'h00, "E", "P", "Y", "T"};
  localparam prefix_t KW_SELF   = {8'h00, 8'h00, "F", "L", "E", "S"};
  localparam prefix_t KW_COLOR  = {8'h00, "R", "O", "L", "O", "C"};
  localparam prefix_t KW_POS    = {8'h00, 8'h00, 8'h00, "S", "O", "P"};
  localparam prefix_t KW_ENTITY = {"Y", "T", "I", "T", "N", "E"};

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // kind of a one-byte token
  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "{", "(": k = KIND_OPEN;
      "}", ")": k = KIND_CLOSE;
      ",":      k = KIND_COMMA;
      ":":      k = KIND_COLON;
      "=":      k = KIND_EQUAL;
      default:  k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // bytes past the word length are zero, so a full compare plus length check suffices
  function automatic kind_t word_kind(input prefix_t p, input logic [LEN_BITS-1:0] len);
    kind_t k;
    if (len == LEN_BITS'(4) && p == KW_TYPE) begin
      k = KIND_TYPE;
    end else if (len == LEN_BITS'(4) && p == KW_SELF) begin
      k = KIND_SELF;
    end else if (len == LEN_BITS'(5) && p == KW_COLOR) begin
      k = KIND_COLOR;
    end else if (len == LEN_BITS'(3) && p == KW_POS) begin
      k = KIND_POS;
    end else if (len == LEN_BITS'(6) && p == KW_ENTITY) begin
      k = KIND_ENTITY;
    end else begin
      k = KIND_NAME;
    end
    return k;
  endfunction

  function automatic logic [31:0] pos_field(input logic [POS_BITS-1:0] p);
    logic [63:0] wide;
    wide = 64'(p);
    return wide[31:0];
  endfunction

  function automatic logic [15:0] len_field(input logic [LEN_BITS-1:0] l);
    logic [31:0] wide;
    wide = 32'(l);
    return wide[15:0];
  endfunction

endpackage

>>> sv/keyword_tokenizer_top.sv
// ---------------------------------------------------------------------------
// keyword_tokenizer_top
// byte-serial lexer: words, keywords, numbers, punctuation and end of text
// ---------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   input    | in_valid / in_ready    | ch, is_end
//   output   | out_valid / out_ready  | token_kind, start_pos, token_length, last
//
// one input beat is classified and folded into the scan state in the cycle it
// is accepted; its zero, one or two tokens land in a four-entry result queue
// and leave at one beat per cycle while out_ready is high, the first no earlier than the cycle after acceptance.
// a beat can be taken every cycle while the queue holds two entries or fewer,
// so only beats that make two tokens (flush plus punctuation or eof) need a
// second output beat. synchronous reset empties the queue and returns the scan
// state to idle at position zero. a stalled output holds its head entry.
// ---------------------------------------------------------------------------
module keyword_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  // input beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        is_end,
  // output beat
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [31:0] start_pos,
  output logic [15:0] token_length,
  output logic        last
);

  // scan state
  kwtok_pkg::mode_t                   scan_mode, scan_mode_next;
  logic [kwtok_pkg::POS_BITS-1:0]     byte_position, byte_position_next;
  logic [kwtok_pkg::POS_BITS-1:0]     token_start, token_start_next;
  logic [kwtok_pkg::LEN_BITS-1:0]     run_length, run_length_next;
  kwtok_pkg::prefix_t                 keyword_prefix, keyword_prefix_next;

  // result queue
  kwtok_pkg::token_t                  queue_mem [kwtok_pkg::QUEUE_DEPTH];
  logic [kwtok_pkg::QUEUE_PTR_BITS-1:0] rd_ptr, wr_ptr;
  logic [kwtok_pkg::QUEUE_CNT_BITS-1:0] count;

  logic in_fire, out_fire;

  // per-beat decode
  logic              end_in, letter, digit, space;
  logic              extend_run, pending, flush_hit, second_hit;
  kwtok_pkg::token_t flush_tok, second_tok, tok0, tok1;
  logic [1:0]        n_push;

  // room for a two-token beat regardless of the output side
  assign in_ready = count <= kwtok_pkg::QUEUE_CNT_BITS'(kwtok_pkg::QUEUE_DEPTH - 2);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = count != '0;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    end_in = is_end || ch == 8'd0;
    letter = kwtok_pkg::is_letter(ch);
    digit  = kwtok_pkg::is_digit(ch);
    space  = kwtok_pkg::is_space(ch);

    // a pending word takes letters and digits, a pending number digits only
    extend_run = !end_in &&
                 ((scan_mode == kwtok_pkg::MODE_WORD && (letter || digit)) ||
                  (scan_mode == kwtok_pkg::MODE_NUMBER && digit));
    pending    = scan_mode != kwtok_pkg::MODE_IDLE;
    flush_hit  = pending && !extend_run;

    flush_tok.kind      = (scan_mode == kwtok_pkg::MODE_WORD)
                          ? kwtok_pkg::word_kind(keyword_prefix, run_length)
                          : kwtok_pkg::KIND_NUMBER;
    flush_tok.start_pos = kwtok_pkg::pos_field(token_start);
    flush_tok.length    = kwtok_pkg::len_field(run_length);
    flush_tok.last      = 1'b0;

    // eof, or a one-byte token for anything that is not space, letter or digit
    second_hit           = end_in || (!extend_run && !space && !letter && !digit);
    second_tok.kind      = end_in ? kwtok_pkg::KIND_EOF : kwtok_pkg::punct_kind(ch);
    second_tok.start_pos = kwtok_pkg::pos_field(byte_position);
    second_tok.length    = end_in ? 16'd0 : 16'd1;
    second_tok.last      = 1'b1;

    // compact the two slots
    if (flush_hit) begin
      tok0      = flush_tok;
      tok0.last = !second_hit;
      tok1      = second_tok;
    end else begin
      tok0 = second_tok;
      tok1 = second_tok;
    end
    n_push = {1'b0, flush_hit} + {1'b0, second_hit};
  end

  // scan state update
  always_comb begin
    scan_mode_next      = scan_mode;
    byte_position_next  = byte_position + kwtok_pkg::POS_BITS'(1);
    token_start_next    = token_start;
    run_length_next     = run_length;
    keyword_prefix_next = keyword_prefix;

    if (end_in) begin
      // new text starts at position zero; the zero byte takes no position
      scan_mode_next     = kwtok_pkg::MODE_IDLE;
      byte_position_next = '0;
      token_start_next   = '0;
      run_length_next    = '0;
    end else if (extend_run) begin
      for (int i = 0; i < kwtok_pkg::PREFIX_BYTES; i++) begin
        if (run_length == kwtok_pkg::LEN_BITS'(i)) begin
          keyword_prefix_next[i] = ch;
        end
      end
      if (run_length != kwtok_pkg::LEN_MAX) begin
        run_length_next = run_length + kwtok_pkg::LEN_BITS'(1);
      end
    end else if (letter || digit) begin
      scan_mode_next      = letter ? kwtok_pkg::MODE_WORD : kwtok_pkg::MODE_NUMBER;
      token_start_next    = byte_position;
      run_length_next     = kwtok_pkg::LEN_BITS'(1);
      keyword_prefix_next = '0;
      keyword_prefix_next[0] = ch;
    end else begin
      scan_mode_next  = kwtok_pkg::MODE_IDLE;
      run_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= kwtok_pkg::MODE_IDLE;
      byte_position  <= '0;
      token_start    <= '0;
      run_length     <= '0;
      keyword_prefix <= '0;
    end else if (in_fire) begin
      scan_mode      <= scan_mode_next;
      byte_position  <= byte_position_next;
      token_start    <= token_start_next;
      run_length     <= run_length_next;
      keyword_prefix <= keyword_prefix_next;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (out_fire) begin
        rd_ptr <= rd_ptr + kwtok_pkg::QUEUE_PTR_BITS'(1);
      end
      if (in_fire) begin
        wr_ptr <= wr_ptr + kwtok_pkg::QUEUE_PTR_BITS'(n_push);
      end
      count <= count
               + (in_fire ? kwtok_pkg::QUEUE_CNT_BITS'(n_push) : '0)
               - (out_fire ? kwtok_pkg::QUEUE_CNT_BITS'(1) : '0);
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (in_fire && n_push != 2'd0) begin
      queue_mem[wr_ptr] <= tok0;
    end
    if (in_fire && n_push == 2'd2) begin
      queue_mem[wr_ptr + kwtok_pkg::QUEUE_PTR_BITS'(1)] <= tok1;
    end
  end

  assign token_kind   = queue_mem[rd_ptr].kind;
  assign start_pos    = queue_mem[rd_ptr].start_pos;
  assign token_length = queue_mem[rd_ptr].length;
  assign last         = queue_mem[rd_ptr].last;

endmodule
